>>> hw/rtl/pid_at_pkg.sv
package pid_at_pkg;

  localparam int unsigned GAIN_SHIFT  = 7;
  localparam logic [31:0] MIN_I_VALUE = 32'd655;

  localparam int unsigned CFG_IDX_W = 3;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OSC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_FAC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_FAC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_D_FAC     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_D_RECIP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_FAC   = 3'd7;

  localparam logic [30:0] RST_MAX_OSC   = 31'd655360;
  localparam logic [30:0] RST_TGT_ANGLE = 31'd1310720;
  localparam logic [30:0] RST_SETTLE    = 31'd16384;
  localparam logic [30:0] RST_INC_FAC   = 31'd72090;
  localparam logic [30:0] RST_DEC_FAC   = 31'd58982;
  localparam logic [30:0] RST_D_FAC     = 31'd78643;
  localparam logic [30:0] RST_D_RECIP   = 31'd54613;
  localparam logic [30:0] RST_YAW_FAC   = 31'd65536;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               armed;
    logic signed [31:0] axis_angle;
    logic [19:0]        time_slice;
    logic [30:0]        p_gain_in;
    logic [30:0]        i_gain_in;
    logic [30:0]        d_gain_in;
  } in_item_t;

  typedef struct packed {
    logic               axis;
    logic               error_valid;
    logic signed [31:0] angle_error;
    logic               gains_valid;
    logic [30:0]        p_gain;
    logic [30:0]        i_gain;
    logic [30:0]        d_gain;
    logic               yaw_valid;
    logic [30:0]        yaw_p_gain;
    logic [30:0]        yaw_i_gain;
    logic [30:0]        yaw_d_gain;
    logic               save_request;
  } out_item_t;

  // 16.16 signed multiply, floor, wrapped to 32 bits
  function automatic logic [31:0] fpmul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return p[47:16];
  endfunction

  function automatic logic [31:0] gain_down(input logic [31:0] w);
    return $signed(w) >>> GAIN_SHIFT;
  endfunction

endpackage

>>> hw/rtl/pid_at_in_if.sv
interface pid_at_in_if;
  logic                 valid;
  logic                 ready;
  pid_at_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pid_at_out_if.sv
interface pid_at_out_if;
  logic                  valid;
  logic                  ready;
  pid_at_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/pid_step_response_autotuner.sv
// Step-response PID autotuner for one attitude axis. Each transfer on in_ch is a sample
// tick, a start or a stop request and gives exactly one result on out_ch via the s1, s2 and
// output registers. Items are taken one per cycle while out_ch is not stalled, but after an
// item that writes gains (an armed start or stop, a finished step cycle) or a configuration
// write, the next item waits in the execute stage while the registered gain-by-factor
// products refresh. Configuration must be written only while idle; nothing enforces it.
module pid_step_response_autotuner (
  input  logic                                clk,
  input  logic                                rst_n,
  pid_at_in_if.sink                           in_ch,
  pid_at_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [pid_at_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [30:0]                         cfg_wdata
);

  // configuration
  logic [30:0] max_osc_r, tgt_angle_r, settle_r, inc_fac_r, dec_fac_r;
  logic [30:0] d_fac_r, d_recip_r, yaw_fac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_osc_r   <= pid_at_pkg::RST_MAX_OSC;
      tgt_angle_r <= pid_at_pkg::RST_TGT_ANGLE;
      settle_r    <= pid_at_pkg::RST_SETTLE;
      inc_fac_r   <= pid_at_pkg::RST_INC_FAC;
      dec_fac_r   <= pid_at_pkg::RST_DEC_FAC;
      d_fac_r     <= pid_at_pkg::RST_D_FAC;
      d_recip_r   <= pid_at_pkg::RST_D_RECIP;
      yaw_fac_r   <= pid_at_pkg::RST_YAW_FAC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pid_at_pkg::CFG_MAX_OSC:   max_osc_r   <= cfg_wdata;
        pid_at_pkg::CFG_TGT_ANGLE: tgt_angle_r <= cfg_wdata;
        pid_at_pkg::CFG_SETTLE:    settle_r    <= cfg_wdata;
        pid_at_pkg::CFG_INC_FAC:   inc_fac_r   <= cfg_wdata;
        pid_at_pkg::CFG_DEC_FAC:   dec_fac_r   <= cfg_wdata;
        pid_at_pkg::CFG_D_FAC:     d_fac_r     <= cfg_wdata;
        pid_at_pkg::CFG_D_RECIP:   d_recip_r   <= cfg_wdata;
        pid_at_pkg::CFG_YAW_FAC:   yaw_fac_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                 s1_valid_r, s2_valid_r, out_valid_r, fresh_r;
  pid_at_pkg::in_item_t s1_item_r, s2_item_r;
  logic [31:0]          s2_dprod_r, s2_neg_angle_r;
  pid_at_pkg::out_item_t out_item_r, res;

  logic exec_fire, s2_take, s1_take, in_take;
  logic gains;

  assign exec_fire = s2_valid_r && fresh_r && (!out_valid_r || out_ch.ready);
  assign s2_take   = !s2_valid_r || exec_fire;
  assign s1_take   = s1_valid_r && s2_take;
  assign in_ch.ready = !s1_valid_r || s2_take;
  assign in_take   = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s2_take)     s2_valid_r <= s1_valid_r;
      out_valid_r <= exec_fire || (out_valid_r && !out_ch.ready);
      fresh_r     <= !(cfg_we || (exec_fire && gains));
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_ch.data;
    if (s1_take) begin
      s2_item_r      <= s1_item_r;
      s2_dprod_r     <= pid_at_pkg::fpmul({1'b0, s1_item_r.d_gain_in}, {1'b0, d_recip_r});
      s2_neg_angle_r <= 32'd0 - s1_item_r.axis_angle;
    end
    if (exec_fire) out_item_r <= res;
  end

  // tuner state
  logic        tune_axis_r, rising_r, seek_r;
  logic [1:0]  cycle_cnt_r;
  logic [31:0] target_r, tap_r, first_pk_r, second_pk_r, elapsed_r;
  logic [31:0] work_p_r, work_i_r, work_d_r;
  logic [31:0] roll_p_r, roll_i_r, roll_d_r;
  logic [31:0] sh_p_r, sh_i_r, sh_d_r;

  logic        tune_axis_nxt, rising_nxt, seek_nxt;
  logic [1:0]  cycle_cnt_nxt;
  logic [31:0] target_nxt, tap_nxt, first_pk_nxt, second_pk_nxt, elapsed_nxt;
  logic [31:0] work_p_nxt, work_i_nxt, work_d_nxt;
  logic [31:0] roll_p_nxt, roll_i_nxt, roll_d_nxt;
  logic [31:0] sh_p_nxt, sh_i_nxt, sh_d_nxt;

  // gain-by-factor products, refreshed every cycle from the state
  logic [31:0] p_inc_r, p_dec_r, d_inc_r, d_dec_r, i_inc_r, i_dec_r, dd_r;
  logic [31:0] yaw_sh_r, yaw_roll_r;

  always_ff @(posedge clk) begin
    p_inc_r    <= pid_at_pkg::fpmul(work_p_r, {1'b0, inc_fac_r});
    p_dec_r    <= pid_at_pkg::fpmul(work_p_r, {1'b0, dec_fac_r});
    d_inc_r    <= pid_at_pkg::fpmul(work_d_r, {1'b0, inc_fac_r});
    d_dec_r    <= pid_at_pkg::fpmul(work_d_r, {1'b0, dec_fac_r});
    i_inc_r    <= pid_at_pkg::fpmul(work_i_r, {1'b0, inc_fac_r});
    i_dec_r    <= pid_at_pkg::fpmul(work_i_r, {1'b0, dec_fac_r});
    dd_r       <= pid_at_pkg::fpmul(work_d_r, {1'b0, d_fac_r});
    yaw_sh_r   <= pid_at_pkg::fpmul(sh_p_r, {1'b0, yaw_fac_r});
    yaw_roll_r <= pid_at_pkg::fpmul(roll_p_r, {1'b0, yaw_fac_r});
  end

  // execute
  logic [31:0] angle, cur, diff, tgt_v, el, amp_old, amp_cur, amp, sp_new, wi_dec, aerr;
  logic [31:0] half_osc, yp, yi, yd;
  logic        rising_v, save, err, yaw, cond, cur_lt_sp;

  assign half_osc = {2'b00, max_osc_r[30:1]};
  assign angle    = s2_item_r.axis_angle;

  always_comb begin
    tune_axis_nxt = tune_axis_r;
    rising_nxt    = rising_r;
    seek_nxt      = seek_r;
    cycle_cnt_nxt = cycle_cnt_r;
    target_nxt    = target_r;
    tap_nxt       = tap_r;
    first_pk_nxt  = first_pk_r;
    second_pk_nxt = second_pk_r;
    elapsed_nxt   = elapsed_r;
    work_p_nxt    = work_p_r;
    work_i_nxt    = work_i_r;
    work_d_nxt    = work_d_r;
    roll_p_nxt    = roll_p_r;
    roll_i_nxt    = roll_i_r;
    roll_d_nxt    = roll_d_r;
    sh_p_nxt      = sh_p_r;
    sh_i_nxt      = sh_i_r;
    sh_d_nxt      = sh_d_r;

    gains = 1'b0;
    yaw   = 1'b0;
    err   = 1'b0;
    save  = 1'b0;
    yp    = '0;
    yi    = '0;
    yd    = '0;
    aerr  = '0;
    rising_v = rising_r;

    tgt_v     = rising_r ? target_r : (32'd0 - target_r);
    cur       = rising_r ? angle : s2_neg_angle_r;
    diff      = rising_r ? (angle - target_r) : (target_r - angle);
    el        = elapsed_r + {12'd0, s2_item_r.time_slice};
    cur_lt_sp = $signed(cur) < $signed(second_pk_r);
    sp_new    = cur_lt_sp ? cur : second_pk_r;
    amp_old   = first_pk_r - second_pk_r;
    amp_cur   = first_pk_r - cur;
    amp       = cur_lt_sp ? amp_cur : amp_old;
    // a reversal on amplitude needs cur above the old trough, so the trough is unchanged then
    cond      = ($signed(el) > $signed({1'b0, settle_r})) ||
                (($signed(amp_old) > $signed(half_osc)) && !cur_lt_sp &&
                 (cur != second_pk_r));
    wi_dec    = ($signed(i_dec_r) < $signed(pid_at_pkg::MIN_I_VALUE)) ?
                pid_at_pkg::MIN_I_VALUE : i_dec_r;

    if (!s2_item_r.armed) begin
      save = (s2_item_r.req_type == pid_at_pkg::REQ_START) && (target_r != 32'd0);
    end else if (s2_item_r.req_type == pid_at_pkg::REQ_STOP) begin
      sh_i_nxt = pid_at_pkg::gain_down(work_i_r);
      sh_d_nxt = pid_at_pkg::gain_down(dd_r);
      if (!tune_axis_r) begin
        roll_p_nxt = sh_p_r;
        roll_i_nxt = sh_i_nxt;
        roll_d_nxt = sh_d_nxt;
        yp = yaw_sh_r;
      end else begin
        yp = yaw_roll_r;
      end
      yi = roll_i_nxt;
      yd = roll_d_nxt;
      gains = 1'b1;
      yaw   = 1'b1;
      tune_axis_nxt = !tune_axis_r;
    end else begin
      if (s2_item_r.req_type == pid_at_pkg::REQ_START) begin
        sh_p_nxt   = {1'b0, s2_item_r.p_gain_in};
        work_p_nxt = {1'b0, s2_item_r.p_gain_in} << pid_at_pkg::GAIN_SHIFT;
        work_i_nxt = {1'b0, s2_item_r.i_gain_in} << pid_at_pkg::GAIN_SHIFT;
        sh_d_nxt   = s2_dprod_r;
        work_d_nxt = s2_dprod_r << pid_at_pkg::GAIN_SHIFT;
        sh_i_nxt   = '0;
        gains = 1'b1;
        cycle_cnt_nxt = 2'd1;
        first_pk_nxt  = '0;
        second_pk_nxt = '0;
        seek_nxt      = 1'b0;
        rising_v      = 1'b0;
      end else begin
        if (!seek_r) begin
          if ($signed(cur) > $signed(first_pk_r)) begin
            first_pk_nxt = cur;
            tap_nxt      = tgt_v;
          end else if ($signed(first_pk_r) > 0) begin
            if (cycle_cnt_r == 2'd0) begin
              work_i_nxt = ($signed(diff) < $signed(half_osc)) ? i_inc_r : wi_dec;
              cycle_cnt_nxt = 2'd1;
              rising_v = !rising_r;
              sh_i_nxt = '0;
              gains = 1'b1;
              first_pk_nxt  = '0;
              second_pk_nxt = '0;
            end else begin
              second_pk_nxt = cur;
              seek_nxt      = 1'b1;
              elapsed_nxt   = '0;
            end
          end
        end else begin
          elapsed_nxt   = el;
          second_pk_nxt = sp_new;
          if (cond) begin
            if ($signed(first_pk_r) > $signed(tap_r)) begin
              work_p_nxt = p_dec_r;
              work_d_nxt = d_inc_r;
            end else if ($signed(amp) > $signed({1'b0, max_osc_r})) begin
              work_d_nxt = d_dec_r;
            end else begin
              work_p_nxt = p_inc_r;
            end
            sh_p_nxt = pid_at_pkg::gain_down(work_p_nxt);
            sh_d_nxt = pid_at_pkg::gain_down(work_d_nxt);
            rising_v = !rising_r;
            first_pk_nxt  = '0;
            second_pk_nxt = '0;
            seek_nxt      = 1'b0;
            if (cycle_cnt_r == 2'd2) begin
              cycle_cnt_nxt = 2'd0;
              sh_i_nxt = pid_at_pkg::gain_down(work_i_r);
            end else begin
              cycle_cnt_nxt = cycle_cnt_r + 2'd1;
            end
            gains = 1'b1;
          end
        end
      end
      if (gains && !tune_axis_r) begin
        roll_p_nxt = sh_p_nxt;
        roll_i_nxt = sh_i_nxt;
        roll_d_nxt = sh_d_nxt;
      end
      rising_nxt = rising_v;
      target_nxt = rising_v ? {1'b0, tgt_angle_r} : (32'd0 - {1'b0, tgt_angle_r});
      aerr = rising_v ? ({1'b0, tgt_angle_r} - angle) :
                        (32'd0 - {1'b0, tgt_angle_r} - angle);
      err = 1'b1;
    end

    res.axis         = tune_axis_r;
    res.error_valid  = err;
    res.angle_error  = aerr;
    res.gains_valid  = gains;
    res.p_gain       = gains ? sh_p_nxt[30:0] : '0;
    res.i_gain       = gains ? sh_i_nxt[30:0] : '0;
    res.d_gain       = gains ? sh_d_nxt[30:0] : '0;
    res.yaw_valid    = yaw;
    res.yaw_p_gain   = yp[30:0];
    res.yaw_i_gain   = yi[30:0];
    res.yaw_d_gain   = yd[30:0];
    res.save_request = save;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tune_axis_r <= 1'b0;
      rising_r    <= 1'b0;
      seek_r      <= 1'b0;
      cycle_cnt_r <= 2'd1;
      target_r    <= '0;
      tap_r       <= '0;
      first_pk_r  <= '0;
      second_pk_r <= '0;
      elapsed_r   <= '0;
      work_p_r    <= '0;
      work_i_r    <= '0;
      work_d_r    <= '0;
      roll_p_r    <= '0;
      roll_i_r    <= '0;
      roll_d_r    <= '0;
      sh_p_r      <= '0;
      sh_i_r      <= '0;
      sh_d_r      <= '0;
    end else if (exec_fire) begin
      tune_axis_r <= tune_axis_nxt;
      rising_r    <= rising_nxt;
      seek_r      <= seek_nxt;
      cycle_cnt_r <= cycle_cnt_nxt;
      target_r    <= target_nxt;
      tap_r       <= tap_nxt;
      first_pk_r  <= first_pk_nxt;
      second_pk_r <= second_pk_nxt;
      elapsed_r   <= elapsed_nxt;
      work_p_r    <= work_p_nxt;
      work_i_r    <= work_i_nxt;
      work_d_r    <= work_d_nxt;
      roll_p_r    <= roll_p_nxt;
      roll_i_r    <= roll_i_nxt;
      roll_d_r    <= roll_d_nxt;
      sh_p_r      <= sh_p_nxt;
      sh_i_r      <= sh_i_nxt;
      sh_d_r      <= sh_d_nxt;
    end
  end

endmodule
